/* rtl/core/llpm_pkg.sv */
`default_nettype none
package llpm_pkg;

	localparam int LLPM_POOL_CELLS = 16;

	localparam logic [2:0] OP_INS_HEAD  = 3'd0;
	localparam logic [2:0] OP_INS_TAIL  = 3'd1;
	localparam logic [2:0] OP_INS_SORT  = 3'd2;
	localparam logic [2:0] OP_DEL_FIRST = 3'd3;
	localparam logic [2:0] OP_DEL_ALL   = 3'd4;
	localparam logic [2:0] OP_DUMP      = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	localparam logic [1:0] MODE_HOLD    = 2'd0;
	localparam logic [1:0] MODE_WAVE    = 2'd1;
	localparam logic [1:0] MODE_COMPACT = 2'd2;
	localparam logic [1:0] MODE_ROTATE  = 2'd3;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data;
		logic [4:0]         removed;
		logic               last;
	} res_t;

	typedef struct packed {
		logic               vld;
		logic signed [31:0] val;
	} cell_t;

	typedef struct packed {
		logic               act;
		logic [2:0]         op;
		logic               pend;
		logic               shift;
		logic               found;
		logic signed [31:0] key;
		logic signed [31:0] carry;
	} wave_t;

	typedef struct packed {
		logic [1:0] mode;
	} ctl_t;

endpackage
`default_nettype wire

/* rtl/core/llpm_cell.sv */
`default_nettype none
module llpm_cell (
	input  wire              clk,
	input  wire              arst_n,
	input  llpm_pkg::ctl_t   ctl,
	input  llpm_pkg::wave_t  lpkt,
	input  wire              lvld,
	input  llpm_pkg::cell_t  rcell,
	output llpm_pkg::cell_t  st,
	output llpm_pkg::wave_t  rpkt,
	output logic             hit
);
	import llpm_pkg::*;

	cell_t st_q, nxt;
	wave_t pkt_q, npkt;
	logic  take;

	always_comb begin
		nxt  = st_q;
		npkt = lpkt;
		hit  = 1'b0;
		take = 1'b0;
		unique case (ctl.mode)
			MODE_WAVE: begin
				if (lpkt.act) begin
					if (lpkt.op == OP_DEL_FIRST || lpkt.op == OP_DEL_ALL) begin
						if (st_q.vld && st_q.val == lpkt.key &&
						    (lpkt.op == OP_DEL_ALL || !lpkt.found)) begin
							nxt.vld    = 1'b0;
							hit        = 1'b1;
							npkt.found = 1'b1;
						end
					end else if (lpkt.pend) begin
						take = !st_q.vld || lpkt.op == OP_INS_HEAD ||
						       (lpkt.op == OP_INS_SORT && !(st_q.val < lpkt.key));
						if (take) begin
							nxt.vld    = 1'b1;
							nxt.val    = lpkt.key;
							npkt.pend  = 1'b0;
							npkt.shift = st_q.vld;
							npkt.carry = st_q.val;
						end
					end else if (lpkt.shift) begin
						nxt.vld    = 1'b1;
						nxt.val    = lpkt.carry;
						npkt.shift = st_q.vld;
						npkt.carry = st_q.val;
					end
				end
			end
			MODE_COMPACT: begin
				if (!st_q.vld) begin
					nxt = rcell;
				end else if (!lvld) begin
					nxt.vld = 1'b0;
				end
			end
			MODE_ROTATE: begin
				nxt = rcell;
			end
			MODE_HOLD: begin
			end
			default: begin
			end
		endcase
		npkt.act = lpkt.act && ctl.mode == MODE_WAVE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			pkt_q <= '0;
		end else begin
			st_q  <= nxt;
			pkt_q <= npkt;
		end
	end

	assign st   = st_q;
	assign rpkt = pkt_q;

endmodule
`default_nettype wire

/* rtl/core/linked_list_pool_manager.sv */
`default_nettype none
// Ordered list of signed 32-bit values held compacted in a row of POOL_CELLS cells, in list
// order. An insert sends a wave down the row, one cell per cycle; a delete takes the same
// wave and, when something was removed, is followed by compaction; a dump rotates the row
// once, one element per cycle while the result side takes items. A full pool or an empty
// dump goes straight to the response. One command is worked on at a time.
module linked_list_pool_manager #(
	parameter int POOL_CELLS = llpm_pkg::LLPM_POOL_CELLS
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cmd_valid,
	output logic           cmd_stall,
	input  llpm_pkg::cmd_t cmd,
	output logic           res_valid,
	input  wire            res_stall,
	output llpm_pkg::res_t res
);
	import llpm_pkg::*;

	localparam int KW = $clog2(POOL_CELLS);
	localparam int RW = $clog2(POOL_CELLS + 1);
	localparam logic [KW-1:0] K_LAST = KW'(POOL_CELLS - 1);
	localparam logic [KW-1:0] K_CMP  = KW'(POOL_CELLS - 2);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WAVE = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_ROT  = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;

	logic [2:0]      state_q;
	logic [KW-1:0]   k_q;
	logic [RW-1:0]   rem_q;
	logic [1:0]      rstat_q;
	logic [2:0]      op_q;
	wave_t           inj_q;
	logic            ovld_q;
	res_t            out_q;

	cell_t           cells [POOL_CELLS];
	wave_t           pkts  [POOL_CELLS];
	logic [POOL_CELLS-1:0] hits, vlds;
	ctl_t            ctl;
	logic            can_emit, step, emit_dump, resp_fire;

	assign can_emit  = !ovld_q || !res_stall;
	assign step      = state_q == S_ROT && (!cells[0].vld || can_emit);
	assign emit_dump = step && cells[0].vld;
	assign resp_fire = state_q == S_RESP && can_emit;
	assign cmd_stall = state_q != S_IDLE;

	always_comb begin
		ctl.mode = MODE_HOLD;
		if (state_q == S_WAVE) begin
			ctl.mode = MODE_WAVE;
		end else if (state_q == S_CMP) begin
			ctl.mode = MODE_COMPACT;
		end else if (step) begin
			ctl.mode = MODE_ROTATE;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < POOL_CELLS; gi++) begin : g_cell
			wave_t lp;
			logic  lv;
			cell_t rc;
			if (gi == 0) begin : g_first
				assign lp = inj_q;
				assign lv = 1'b1;
			end else begin : g_mid
				assign lp = pkts[gi-1];
				assign lv = cells[gi-1].vld;
			end
			if (gi == POOL_CELLS - 1) begin : g_end
				assign rc = (ctl.mode == MODE_ROTATE) ? cells[0] : '0;
			end else begin : g_inner
				assign rc = cells[gi+1];
			end
			llpm_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctl   (ctl),
				.lpkt  (lp),
				.lvld  (lv),
				.rcell (rc),
				.st    (cells[gi]),
				.rpkt  (pkts[gi]),
				.hit   (hits[gi])
			);
			assign vlds[gi] = cells[gi].vld;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			rem_q   <= '0;
			rstat_q <= ST_OK;
			op_q    <= OP_INS_HEAD;
			inj_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q  <= cmd.opcode;
						rem_q <= '0;
						if (cmd.opcode == OP_INS_HEAD || cmd.opcode == OP_INS_TAIL ||
						    cmd.opcode == OP_INS_SORT) begin
							if (cells[POOL_CELLS-1].vld) begin
								rstat_q <= ST_FULL;
								state_q <= S_RESP;
							end else begin
								inj_q   <= '{act: 1'b1, op: cmd.opcode, pend: 1'b1,
								             shift: 1'b0, found: 1'b0, key: cmd.value,
								             carry: '0};
								state_q <= S_WAVE;
							end
						end else if (cmd.opcode == OP_DEL_FIRST ||
						             cmd.opcode == OP_DEL_ALL) begin
							inj_q   <= '{act: 1'b1, op: cmd.opcode, pend: 1'b0,
							             shift: 1'b0, found: 1'b0, key: cmd.value,
							             carry: '0};
							state_q <= S_WAVE;
						end else if (cmd.opcode == OP_DUMP) begin
							k_q <= '0;
							if (!cells[0].vld) begin
								rstat_q <= ST_EMPTY;
								state_q <= S_RESP;
							end else begin
								state_q <= S_ROT;
							end
						end
					end
				end
				S_WAVE: begin
					inj_q.act <= 1'b0;
					rem_q <= rem_q + RW'(|hits);
					if (pkts[POOL_CELLS-1].act) begin
						k_q <= '0;
						if (op_q != OP_DEL_FIRST && op_q != OP_DEL_ALL) begin
							rstat_q <= ST_OK;
							state_q <= S_RESP;
						end else if (rem_q == '0) begin
							rstat_q <= ST_NOT_FOUND;
							state_q <= S_RESP;
						end else begin
							rstat_q <= ST_OK;
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					k_q <= k_q + 1'b1;
					if (k_q == K_CMP) begin
						state_q <= S_RESP;
					end
				end
				S_ROT: begin
					if (step) begin
						k_q <= k_q + 1'b1;
						if (k_q == K_LAST) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RESP: begin
					if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (can_emit) begin
			ovld_q <= resp_fire || emit_dump;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_fire) begin
			out_q.status  <= rstat_q;
			out_q.data    <= '0;
			out_q.removed <= (rstat_q == ST_OK) ? 5'(rem_q) : 5'd0;
			out_q.last    <= 1'b1;
		end else if (emit_dump) begin
			out_q.status  <= ST_OK;
			out_q.data    <= cells[0].val;
			out_q.removed <= 5'd0;
			out_q.last    <= (k_q == K_LAST) || !cells[1].vld;
		end
	end

	assign res_valid = ovld_q;
	assign res       = out_q;

	a_compact : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((vlds & ~{vlds[POOL_CELLS-2:0], 1'b1}) == '0))
		else $error("cells not compacted while idle");

	a_busy : assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall && cmd.opcode <= OP_DUMP)
		|=> (state_q != S_IDLE))
		else $error("accepted command did not start work");

	a_wave_only : assert property (@(posedge clk) disable iff (!arst_n)
		(|hits) |-> (state_q == S_WAVE))
		else $error("cell removed outside a wave");

endmodule
`default_nettype wire
